FILE: sv/bped_pkg.sv
// shared types, constants and event mapping for the button press event detector
`timescale 1ns / 1ps

package bped_pkg;

    localparam int TIME_BITS  = 32;
    localparam int CFG_BITS   = 16;
    localparam int CFG_ADDR_BITS = 2;
    localparam int NUM_BUTTONS = 3;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd1500;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_TWO_BUTTON = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_NEXT     = 3'd1,
        EV_PREV     = 3'd2,
        EV_SETTINGS = 3'd3,
        EV_CYCLE    = 3'd4,
        EV_EXIT     = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        BTN_ONE   = 2'd0,
        BTN_TWO   = 2'd1,
        BTN_THREE = 2'd2
    } button_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_time;
        logic [CFG_BITS-1:0] long_press_ms;
        logic                two_button_mode;
    } cfg_t;

    typedef struct packed {
        logic long_due;
        logic short_pend;
    } btn_status_t;

    // timestamp taken modulo 2^TIME_BITS
    function automatic time_t to_time(input logic [31:0] v);
        logic [63:0] w;
        begin
            w = {32'd0, v};
            return w[TIME_BITS-1:0];
        end
    endfunction

    function automatic time_t cfg_to_time(input logic [CFG_BITS-1:0] v);
        logic [63:0] w;
        begin
            w = {{(64-CFG_BITS){1'b0}}, v};
            return w[TIME_BITS-1:0];
        end
    endfunction

    function automatic event_t short_event(input button_t k, input logic settings,
                                           input logic two_mode);
        event_t ev;
        begin
            ev = EV_NONE;
            if (!settings) begin
                case (k)
                    BTN_ONE: ev = EV_NEXT;
                    BTN_TWO: ev = EV_PREV;
                    default: ev = two_mode ? EV_NONE : EV_SETTINGS;
                endcase
            end
            else if (two_mode) begin
                case (k)
                    BTN_ONE: ev = EV_CYCLE;
                    BTN_TWO: ev = EV_PREV;
                    default: ev = EV_NONE;
                endcase
            end
            else begin
                case (k)
                    BTN_ONE: ev = EV_NEXT;
                    BTN_TWO: ev = EV_PREV;
                    default: ev = EV_CYCLE;
                endcase
            end
            return ev;
        end
    endfunction

    function automatic event_t long_event(input button_t k, input logic settings,
                                          input logic two_mode);
        event_t ev;
        begin
            ev = EV_NONE;
            if (k == BTN_THREE)
                ev = EV_EXIT;
            else if (two_mode && k == BTN_TWO)
                ev = settings ? EV_EXIT : EV_SETTINGS;
            return ev;
        end
    endfunction

endpackage

FILE: sv/button_press_event_detector.sv
// top level: poll input register, button qualifiers, event priority and result register
`timescale 1ns / 1ps

// Three active-low buttons are debounced and classified into short and long
// presses, one poll transfer in giving one event code transfer out. A poll is
// taken into an input register; once the result register is free or being
// read, the buttons are stepped (button three only outside two-button mode)
// and the first due event is chosen into the result register. A new poll can
// be taken every cycle unless a waiting result holds a full input register.
// Configuration writes are taken at any time but must only be made while idle.
module button_press_event_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [bped_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [bped_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [31:0]                         now_ms,
    input  logic                                pin_level_one,
    input  logic                                pin_level_two,
    input  logic                                pin_level_three,
    input  logic                                settings_active,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          event_code
);
    import bped_pkg::*;

    cfg_t cfg;

    logic        s1_valid_reg;
    logic [31:0] s1_now_reg;
    logic [NUM_BUTTONS-1:0] s1_pin_reg;
    logic        s1_settings_reg;
    logic        out_valid_reg;
    event_t      out_code_reg;

    logic        advance;
    time_t       now_t;
    logic [NUM_BUTTONS-1:0] btn_step;
    logic [NUM_BUTTONS-1:0] btn_cand;
    logic [NUM_BUTTONS-1:0] btn_take;
    btn_status_t status [NUM_BUTTONS];
    event_t      code [NUM_BUTTONS];
    event_t      ev0, ev1, ev2;
    logic        two_mode;

    bped_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign two_mode = cfg.two_button_mode;
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign now_t    = to_time(s1_now_reg);

    assign btn_step[0] = advance;
    assign btn_step[1] = advance;
    assign btn_step[2] = advance && !two_mode;

    genvar k;
    generate
        for (k = 0; k < NUM_BUTTONS; k++)
        begin : g_btn
            bped_button u_button (
                .clk     (clk),
                .rst_n   (rst_n),
                .step    (btn_step[k]),
                .active  (~s1_pin_reg[k]),
                .now     (now_t),
                .cfg     (cfg),
                .consume (btn_take[k]),
                .status  (status[k])
            );
            assign code[k] = status[k].long_due
                ? long_event(button_t'(k), s1_settings_reg, two_mode)
                : short_event(button_t'(k), s1_settings_reg, two_mode);
        end
    endgenerate

    assign btn_cand[0] = status[0].long_due | status[0].short_pend;
    assign btn_cand[1] = status[1].long_due | status[1].short_pend;
    assign btn_cand[2] = (status[2].long_due | status[2].short_pend) & ~two_mode;

    // first button in order with a mapped event wins; unmapped ones before it are still consumed
    assign btn_take[0] = btn_cand[0];
    assign ev0         = btn_take[0] ? code[0] : EV_NONE;
    assign btn_take[1] = btn_cand[1] && (ev0 == EV_NONE);
    assign ev1         = btn_take[1] ? code[1] : ev0;
    assign btn_take[2] = btn_cand[2] && (ev1 == EV_NONE);
    assign ev2         = btn_take[2] ? code[2] : ev1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_now_reg      <= now_ms;
            s1_pin_reg      <= {pin_level_three, pin_level_two, pin_level_one};
            s1_settings_reg <= settings_active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= ev2;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = out_code_reg;

endmodule

FILE: sv/bped_cfg.sv
// configuration registers with index decode
`timescale 1ns / 1ps

module bped_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [bped_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [bped_pkg::CFG_BITS-1:0]  cfg_wdata,
    output bped_pkg::cfg_t                 cfg
);
    import bped_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_DEBOUNCE:   cfg_next.debounce_time   = cfg_wdata;
                REG_LONG_PRESS: cfg_next.long_press_ms   = cfg_wdata;
                REG_TWO_BUTTON: cfg_next.two_button_mode = cfg_wdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms   <= LONG_PRESS_RESET;
            cfg_reg.two_button_mode <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/bped_button.sv
// per-button debounce, press timing and short/long event marks
`timescale 1ns / 1ps

module bped_button (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   active,
    input  bped_pkg::time_t        now,
    input  bped_pkg::cfg_t         cfg,
    input  logic                   consume,
    output bped_pkg::btn_status_t  status
);
    import bped_pkg::*;

    logic  last_reg, last_next;
    logic  pressed_reg, pressed_next;
    logic  long_done_reg, long_done_next, long_done_q;
    logic  short_reg, short_next, short_q;
    time_t change_time_reg, change_time_next;
    time_t press_time_reg, press_time_next;
    logic  changed;
    logic  debounce_hit;
    logic  long_hit;
    logic  long_due;

    assign changed      = active != last_reg;
    assign debounce_hit = (now - change_time_reg) >= cfg_to_time(cfg.debounce_time);

    // qualify
    always_comb
    begin
        last_next        = last_reg;
        pressed_next     = pressed_reg;
        long_done_q      = long_done_reg;
        short_q          = short_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        if (changed)
        begin
            if (pressed_reg && !long_done_reg)
                short_q = 1'b1;
            last_next        = active;
            change_time_next = now;
            pressed_next     = 1'b0;
            long_done_q      = 1'b0;
        end
        else if (active && !pressed_reg && debounce_hit)
        begin
            pressed_next    = 1'b1;
            press_time_next = now;
        end
    end

    assign long_hit = (now - press_time_next) >= cfg_to_time(cfg.long_press_ms);
    assign long_due = pressed_next && !long_done_q && long_hit;

    assign status.long_due   = long_due;
    assign status.short_pend = short_q;

    // consumption of the chosen event
    assign long_done_next = long_done_q | (consume & long_due);
    assign short_next     = short_q & ~(consume & ~long_due);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg        <= 1'b0;
            pressed_reg     <= 1'b0;
            long_done_reg   <= 1'b0;
            short_reg       <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
        end
        else if (step)
        begin
            last_reg        <= last_next;
            pressed_reg     <= pressed_next;
            long_done_reg   <= long_done_next;
            short_reg       <= short_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
        end
    end

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the button press event detector with directed table and randomised phases
`timescale 1ns / 1ps

module tb_top;

    import bped_pkg::*;

    typedef enum bit {ROW_POLL, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        reg_index_t    reg_idx;
        logic [15:0]   value;
        logic [31:0]   now;
        logic [2:0]    pins;
        logic          settings;
        logic          typed;
        event_t        code;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 32;

    // pins are {three, two, one}, active low
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0000, 3'b111, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd100, 3'b110, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd120, 3'b110, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd130, 3'b111, 1'b0, 1'b1, EV_NEXT},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd200, 3'b101, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd220, 3'b101, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd230, 3'b111, 1'b1, 1'b1, EV_PREV},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd300, 3'b011, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd320, 3'b011, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd1820, 3'b011, 1'b0, 1'b1, EV_EXIT},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd1900, 3'b111, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd2000, 3'b011, 1'b1, 1'b0, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd2020, 3'b011, 1'b1, 1'b0, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'd2030, 3'b111, 1'b1, 1'b1, EV_CYCLE},
        // timestamp wraps between change and press
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'hFFFF_FFFF, 3'b110, 1'b0, 1'b0, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0013, 3'b110, 1'b0, 1'b0, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0014, 3'b111, 1'b0, 1'b1, EV_NEXT},
        // long press on button one maps to nothing but is still consumed
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0100, 3'b110, 1'b0, 1'b0, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0114, 3'b110, 1'b0, 1'b0, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_06F0, 3'b110, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0700, 3'b111, 1'b0, 1'b1, EV_NONE},
        '{ROW_CFG, REG_TWO_BUTTON, 16'd1, 32'd0, 3'b111, 1'b0, 1'b0, EV_NONE},
        '{ROW_CFG, REG_DEBOUNCE, 16'd0, 32'd0, 3'b111, 1'b0, 1'b0, EV_NONE},
        '{ROW_CFG, REG_LONG_PRESS, 16'hFFFF, 32'd0, 3'b111, 1'b0, 1'b0, EV_NONE},
        // button three ignored, pending short of button two kept for next poll
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0800, 3'b000, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0801, 3'b000, 1'b0, 1'b0, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0802, 3'b111, 1'b1, 1'b1, EV_CYCLE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0803, 3'b111, 1'b1, 1'b1, EV_PREV},
        '{ROW_CFG, REG_TWO_BUTTON, 16'd0, 32'd0, 3'b111, 1'b0, 1'b0, EV_NONE},
        '{ROW_CFG, REG_LONG_PRESS, 16'd0, 32'd0, 3'b111, 1'b0, 1'b0, EV_NONE},
        // zero debounce and zero hold fire on the first check
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0900, 3'b011, 1'b0, 1'b1, EV_NONE},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, 32'h0000_0900, 3'b011, 1'b0, 1'b1, EV_EXIT}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_BITS-1:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] now_ms;
    logic        pin_level_one;
    logic        pin_level_two;
    logic        pin_level_three;
    logic        settings_active;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  event_code;

    // predictor copy of the block state and settings
    bit          lvl_active [3];
    bit          held [3];
    bit          long_seen [3];
    bit          short_armed [3];
    bit [31:0]   t_change [3];
    bit [31:0]   t_press [3];
    bit [15:0]   debounce_cfg = DEBOUNCE_RESET;
    bit [15:0]   long_cfg = LONG_PRESS_RESET;
    bit          two_mode_cfg = 1'b0;

    event_t      expected_events [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    int          free_left = 0;
    int          rx_count = 0;
    bit          pressure_done = 1'b0;
    bit [31:0]   cur_now = 32'h0000_1000;
    bit [2:0]    cur_pins = 3'b111;
    bit          cur_settings = 1'b0;

    button_press_event_detector DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .now_ms          (now_ms),
        .pin_level_one   (pin_level_one),
        .pin_level_two   (pin_level_two),
        .pin_level_three (pin_level_three),
        .settings_active (settings_active),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .event_code      (event_code)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic event_t predict_event(input bit [31:0] now, input bit [2:0] pins,
                                             input bit settings);
        event_t    ev;
        int        n;
        int        k;
        bit        act;
        bit [31:0] elapsed;
        ev = EV_NONE;
        n = two_mode_cfg ? 2 : 3;
        for (k = 0; k < n; k++)
        begin
            act = !pins[k];
            elapsed = now - t_change[k];
            if (act != lvl_active[k])
            begin
                if (held[k] && !long_seen[k])
                    short_armed[k] = 1'b1;
                lvl_active[k] = act;
                t_change[k] = now;
                held[k] = 1'b0;
                long_seen[k] = 1'b0;
            end
            else if (act && !held[k] && elapsed >= {16'd0, debounce_cfg})
            begin
                held[k] = 1'b1;
                t_press[k] = now;
            end
            elapsed = now - t_press[k];
            if (ev == EV_NONE)
            begin
                if (held[k] && !long_seen[k] && elapsed >= {16'd0, long_cfg})
                begin
                    long_seen[k] = 1'b1;
                    if (k == 2)
                        ev = EV_EXIT;
                    else if (k == 1 && two_mode_cfg)
                        ev = settings ? EV_EXIT : EV_SETTINGS;
                end
                else if (short_armed[k])
                begin
                    short_armed[k] = 1'b0;
                    if (k == 0)
                        ev = (settings && two_mode_cfg) ? EV_CYCLE : EV_NEXT;
                    else if (k == 1)
                        ev = EV_PREV;
                    else if (!two_mode_cfg)
                        ev = settings ? EV_CYCLE : EV_SETTINGS;
                end
            end
        end
        return ev;
    endfunction

    task automatic write_reg(input reg_index_t idx, input bit [15:0] value);
        if (in_valid)
            in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            REG_DEBOUNCE:   debounce_cfg = value;
            REG_LONG_PRESS: long_cfg = value;
            REG_TWO_BUTTON: two_mode_cfg = value[0];
            default: ;
        endcase
    endtask

    task automatic send_poll(input bit [31:0] now, input bit [2:0] pins, input bit settings,
                             input bit typed, input event_t code);
        event_t predicted;
        int     gap;
        int     r;
        if (cfg_wen)
            cfg_wen <= 1'b0;
        in_valid        <= 1'b1;
        now_ms          <= now;
        pin_level_one   <= pins[0];
        pin_level_two   <= pins[1];
        pin_level_three <= pins[2];
        settings_active <= settings;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_event(now, pins, settings);
        expected_events.push_back(typed ? code : predicted);
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            r = $urandom_range(0, 31);
            if (r == 0)
                burst_left = $urandom_range(20, 60);
            else if (r >= 16 && r < 28)
                gap = $urandom_range(1, 3);
            else if (r >= 28 && r < 31)
                gap = $urandom_range(4, 10);
            else if (r == 31)
                gap = $urandom_range(20, 50);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_phase(input bit [15:0] db, input bit [15:0] lp, input bit two,
                             input int count);
        int        i;
        int        b;
        int        step_kind;
        bit [31:0] step;
        write_reg(REG_DEBOUNCE, db);
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_TWO_BUTTON, {15'd0, two});
        for (i = 0; i < count; i++)
        begin
            step_kind = $urandom_range(0, 9);
            if (step_kind < 4)
                step = $urandom_range(0, 3);
            else if (step_kind < 6)
                step = $urandom_range(0, db + 4);
            else if (step_kind < 8)
                step = $urandom_range((lp > 4) ? lp - 4 : 0, lp + 4);
            else if (step_kind == 8)
                step = $urandom_range((db > 4) ? db - 4 : 0, db + 4);
            else
                step = $urandom;
            cur_now = cur_now + step;
            if ($urandom_range(0, 15) == 0)
                cur_pins = 3'($urandom);
            else
                for (b = 0; b < 3; b++)
                    if ($urandom_range(0, 7) == 0)
                        cur_pins[b] = ~cur_pins[b];
            if ($urandom_range(0, 7) == 0)
                cur_settings = ~cur_settings;
            send_poll(cur_now, cur_pins, cur_settings, 1'b0, EV_NONE);
        end
    endtask

    // result side with random stalls and hold-offs, and one long hold-off after 100 results
    always @(posedge clk)
    begin
        int r;
        if (rst_n && out_valid && out_ready)
            rx_count++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!pressure_done && rx_count >= 100)
        begin
            pressure_done = 1'b1;
            hold_left = 80;
            out_ready <= 1'b0;
        end
        else if (free_left > 0)
        begin
            free_left--;
            out_ready <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 31);
            if (r < 22)
                out_ready <= 1'b1;
            else if (r < 28)
                out_ready <= 1'b0;
            else if (r < 30)
            begin
                free_left = $urandom_range(30, 80);
                out_ready <= 1'b1;
            end
            else if (r == 30)
            begin
                hold_left = $urandom_range(1, 4);
                out_ready <= 1'b0;
            end
            else
            begin
                hold_left = $urandom_range(15, 40);
                out_ready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected event_code transfer, expected none, got %0d",
                         $time, event_code);
                mismatches++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (event_code !== want)
                begin
                    $display("%0t: event_code expected %0d, got %0d", $time, want, event_code);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int i;
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wen         = 1'b0;
        cfg_addr        = REG_DEBOUNCE;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        now_ms          = '0;
        pin_level_one   = 1'b1;
        pin_level_two   = 1'b1;
        pin_level_three = 1'b1;
        settings_active = 1'b0;
        out_ready       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_poll(directed_rows[i].now, directed_rows[i].pins,
                          directed_rows[i].settings, directed_rows[i].typed,
                          directed_rows[i].code);
        end

        run_phase(16'd20, 16'd1500, 1'b0, 130);
        run_phase(16'd0, 16'd0, 1'b0, 100);
        run_phase(16'd0, 16'd0, 1'b1, 100);
        run_phase(16'hFFFF, 16'hFFFF, 1'b0, 100);
        run_phase(16'd3, 16'd12, 1'b1, 110);
        run_phase(16'd5, 16'd40, 1'b0, 110);
        run_phase(16'($urandom_range(0, 50)), 16'($urandom_range(0, 200)),
                  1'($urandom_range(0, 1)), 100);

        if (in_valid)
            in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
